### rtl/core/vfcp_pkg.sv
// Package for the glyph font container parser: result record type, phase and
// kind codes, status codes and container constants. No dependencies.
`timescale 1ns / 1ps
package vfcp_pkg;

  typedef enum logic [2:0] {
    PhMarker  = 3'd0,
    PhHeader  = 3'd1,
    PhUnits   = 3'd2,
    PhGlyph   = 3'd3,
    PhContour = 3'd4,
    PhPoint   = 3'd5,
    PhDone    = 3'd6
  } phase_e;

  localparam logic [2:0] KindHeader  = 3'd0;
  localparam logic [2:0] KindGlyph   = 3'd1;
  localparam logic [2:0] KindContour = 3'd2;
  localparam logic [2:0] KindPoint   = 3'd3;
  localparam logic [2:0] KindStatus  = 3'd4;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadMarker = 3'd1;
  localparam logic [2:0] StBadFlags  = 3'd2;
  localparam logic [2:0] StBadHeader = 3'd3;
  localparam logic [2:0] StTruncated = 3'd4;

  localparam logic [7:0] Marker0 = 8'h61;
  localparam logic [7:0] Marker1 = 8'h66;
  localparam logic [7:0] Marker2 = 8'h21;
  localparam logic [7:0] Marker3 = 8'h3F;

  localparam logic [15:0] FlagLen16     = 16'h0001;
  localparam logic [15:0] FlagWide      = 16'h0002;
  localparam logic [15:0] FlagsUnknown  = 16'hFFFC;
  localparam logic [15:0] DefaultUnits  = 16'd128;
  localparam logic [16:0] Sat17         = 17'h1FFFF;

  localparam int unsigned RecBytes = 13;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        codepoint;
    logic signed [15:0] bbox_x;
    logic signed [15:0] bbox_y;
    logic [15:0]        bbox_w;
    logic [15:0]        bbox_h;
    logic [15:0]        advance;
    logic [15:0]        count_value;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [2:0]         status;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

### rtl/core/vfcp_front.sv
// Front part of the parser: takes byte transactions, assembles records and
// classifies them into zero, one or two result records. Uses vfcp_pkg.
`timescale 1ns / 1ps
module vfcp_front import vfcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_file_i,
  output push_t      push_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  bpos_q, bpos_d;
  logic [7:0]  rec_q [RecBytes];
  logic [15:0] flags_q, flags_d;
  logic [15:0] glyphs_q, glyphs_d;
  logic [15:0] dc_q, dc_d;
  logic [15:0] dp_q, dp_d;
  logic [16:0] cc_q, cc_d;
  logic [16:0] cp_q, cp_d;
  logic [15:0] plc_q, plc_d;

  function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[17] ? Sat17 : s[16:0];
  endfunction

  function automatic logic [15:0] sx8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

  always_comb begin
    logic [7:0]  cur [RecBytes];
    logic [3:0]  bn;
    logic [3:0]  len;
    logic        wide;
    logic        item_v;
    logic        fin_v;
    logic [2:0]  code;
    result_t     item;
    result_t     fin;
    logic [15:0] w01;
    logic [15:0] v;
    logic [16:0] csum;
    logic [15:0] h16;
    logic [15:0] nflags;
    logic [15:0] ng;
    logic [16:0] partial;

    for (int i = 0; i < RecBytes; i++) begin
      cur[i] = (bpos_q == 4'(i)) ? data_byte_i : rec_q[i];
    end
    phase_d  = phase_q;
    bpos_d   = bpos_q;
    flags_d  = flags_q;
    glyphs_d = glyphs_q;
    dc_d     = dc_q;
    dp_d     = dp_q;
    cc_d     = cc_q;
    cp_d     = cp_q;
    plc_d    = plc_q;
    item_v   = 1'b0;
    fin_v    = 1'b0;
    code     = StOk;
    item     = '0;
    fin      = '0;
    wide     = (flags_q & FlagWide) != 16'd0;
    bn       = bpos_q + 4'd1;
    w01      = {cur[0], cur[1]};
    v        = 16'd0;
    csum     = 17'd0;
    nflags   = 16'd0;
    ng       = 16'd0;
    partial  = 17'd0;
    h16      = {(bpos_q > 4'd0) ? rec_q[0] : 8'd0, (bpos_q > 4'd1) ? rec_q[1] : 8'd0};
    case (phase_q)
      PhMarker:  len = 4'd4;
      PhHeader:  len = 4'd8;
      PhUnits:   len = 4'd2;
      PhGlyph:   len = wide ? 4'd13 : 4'd8;
      PhContour: len = ((flags_q & FlagLen16) != 16'd0) ? 4'd2 : 4'd1;
      default:   len = wide ? 4'd4 : 4'd2;
    endcase

    if (accept_i) begin
      if (end_of_file_i) begin
        if (phase_q != PhDone) begin
          fin_v = 1'b1;
          case (phase_q)
            PhMarker: code = StBadMarker;
            PhHeader: code = ((h16 & FlagsUnknown) != 16'd0) ? StBadFlags : StTruncated;
            PhGlyph:  code = (cc_q > {1'b0, dc_q}) ? StBadHeader : StTruncated;
            PhContour: begin
              if (((flags_q & FlagLen16) != 16'd0) && bpos_q == 4'd1) begin
                partial = {1'b0, rec_q[0], 8'd0};
              end
              code = (sat_add(cp_q, partial) > {1'b0, dp_q}) ? StBadHeader : StTruncated;
            end
            default: code = StTruncated;
          endcase
        end
        phase_d  = PhMarker;
        bpos_d   = 4'd0;
        flags_d  = '0;
        glyphs_d = '0;
        dc_d     = '0;
        dp_d     = '0;
        cc_d     = '0;
        cp_d     = '0;
        plc_d    = '0;
      end else if (phase_q != PhDone) begin
        bpos_d = bn;
        if (bn >= len) begin
          bpos_d = 4'd0;
          case (phase_q)
            PhMarker: begin
              if (cur[0] != Marker0 || cur[1] != Marker1 || cur[2] != Marker2 ||
                  cur[3] != Marker3) begin
                fin_v = 1'b1;
                code  = StBadMarker;
              end else begin
                phase_d = PhHeader;
              end
            end
            PhHeader: begin
              nflags   = w01;
              ng       = {cur[2], cur[3]};
              flags_d  = nflags;
              glyphs_d = ng;
              dc_d     = {cur[4], cur[5]};
              dp_d     = {cur[6], cur[7]};
              if ((nflags & FlagsUnknown) != 16'd0) begin
                fin_v = 1'b1;
                code  = StBadFlags;
              end else if ((nflags & FlagWide) != 16'd0) begin
                phase_d = PhUnits;
              end else begin
                item_v = 1'b1;
                item.kind        = KindHeader;
                item.codepoint   = ng;
                item.bbox_w      = {cur[4], cur[5]};
                item.bbox_h      = {cur[6], cur[7]};
                item.advance     = nflags;
                item.count_value = DefaultUnits;
                if (ng == 16'd0) fin_v = 1'b1;
                else phase_d = PhGlyph;
              end
            end
            PhUnits: begin
              if (w01 == 16'd0) begin
                fin_v = 1'b1;
                code  = StBadHeader;
              end else begin
                item_v = 1'b1;
                item.kind        = KindHeader;
                item.codepoint   = glyphs_q;
                item.bbox_w      = dc_q;
                item.bbox_h      = dp_q;
                item.advance     = flags_q;
                item.count_value = w01;
                if (glyphs_q == 16'd0) fin_v = 1'b1;
                else phase_d = PhGlyph;
              end
            end
            PhGlyph: begin
              item_v = 1'b1;
              item.kind      = KindGlyph;
              item.codepoint = w01;
              if (wide) begin
                item.bbox_x  = {cur[2], cur[3]};
                item.bbox_y  = {cur[4], cur[5]};
                item.bbox_w  = {cur[6], cur[7]};
                item.bbox_h  = {cur[8], cur[9]};
                item.advance = {cur[10], cur[11]};
                v            = {8'd0, cur[12]};
              end else begin
                item.bbox_x  = sx8(cur[2]);
                item.bbox_y  = sx8(cur[3]);
                item.bbox_w  = {8'd0, cur[4]};
                item.bbox_h  = {8'd0, cur[5]};
                item.advance = {8'd0, cur[6]};
                v            = {8'd0, cur[7]};
              end
              item.count_value = v;
              csum     = sat_add(cc_q, {1'b0, v});
              cc_d     = csum;
              glyphs_d = glyphs_q - 16'd1;
              if (glyphs_q == 16'd1) begin
                if (csum > {1'b0, dc_q}) begin
                  fin_v = 1'b1;
                  code  = StBadHeader;
                end else if (csum == 17'd0) begin
                  fin_v = 1'b1;
                end else begin
                  phase_d = PhContour;
                end
              end
            end
            PhContour: begin
              v = ((flags_q & FlagLen16) != 16'd0) ? w01 : {8'd0, cur[0]};
              item_v = 1'b1;
              item.kind        = KindContour;
              item.count_value = v;
              csum  = sat_add(cp_q, {1'b0, v});
              cp_d  = csum;
              cc_d  = cc_q - 17'd1;
              if (cc_q == 17'd1) begin
                if (csum > {1'b0, dp_q}) begin
                  fin_v = 1'b1;
                  code  = StBadHeader;
                end else begin
                  plc_d = csum[15:0];
                  if (csum[15:0] == 16'd0) fin_v = 1'b1;
                  else phase_d = PhPoint;
                end
              end
            end
            PhPoint: begin
              item_v = 1'b1;
              item.kind = KindPoint;
              if (wide) begin
                item.point_x = w01;
                item.point_y = {cur[2], cur[3]};
              end else begin
                item.point_x = sx8(cur[0]);
                item.point_y = sx8(cur[1]);
              end
              plc_d = plc_q - 16'd1;
              if (plc_q == 16'd1) fin_v = 1'b1;
            end
            default: ;
          endcase
          if (fin_v) phase_d = PhDone;
        end
      end
    end

    fin.kind   = KindStatus;
    fin.status = code;
    fin.last_of_run = 1'b1;
    item.last_of_run = !fin_v;
    push_o.count  = {1'b0, item_v} + {1'b0, fin_v};
    push_o.first  = item_v ? item : fin;
    push_o.second = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhMarker;
      bpos_q   <= '0;
      flags_q  <= '0;
      glyphs_q <= '0;
      dc_q     <= '0;
      dp_q     <= '0;
      cc_q     <= '0;
      cp_q     <= '0;
      plc_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      bpos_q   <= bpos_d;
      flags_q  <= flags_d;
      glyphs_q <= glyphs_d;
      dc_q     <= dc_d;
      dp_q     <= dp_d;
      cc_q     <= cc_d;
      cp_q     <= cp_d;
      plc_q    <= plc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !end_of_file_i && phase_q != PhDone && bpos_q < 4'(RecBytes)) begin
      rec_q[bpos_q] <= data_byte_i;
    end
  end

endmodule

### rtl/core/vfcp_back.sv
// Back part of the parser: a short result queue that takes up to two records
// per cycle and hands one record per transaction to the output. Uses vfcp_pkg.
`timescale 1ns / 1ps
module vfcp_back import vfcp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t head_o
);

  localparam logic [QPtrW:0] DepthC = (QPtrW + 1)'(QDepth);

  result_t          mem_q [QDepth];
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW:0]   cnt_q, cnt_d;
  logic             pop;
  logic [QPtrW-1:0] wr_next;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign head_o      = mem_q[rd_q];
  assign full_o      = cnt_q > (DepthC - (QPtrW + 1)'(2));
  assign wr_next     = wr_q + 1'b1;

  always_comb begin
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    wr_d  = wr_q + QPtrW'(push_i.count);
    cnt_d = cnt_q + (QPtrW + 1)'(push_i.count) - (QPtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr_next] <= push_i.second;
  end

endmodule

### rtl/core/vector_font_container_parser.sv
// Each result is written into the queue by the byte transaction that completes its record.
// Throughput: one byte per cycle; the input stalls only while three or more results wait in
// the four-entry queue, so a byte that yields two results causes no stall while the output
// is taken every cycle.
// The front parser state and the four-entry result queue clear on an asynchronous reset;
// the record byte registers hold no reset value and are written before they are read.
`timescale 1ns / 1ps
module vector_font_container_parser import vfcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [15:0] codepoint_o,
  output logic signed [15:0] bbox_x_o,
  output logic signed [15:0] bbox_y_o,
  output logic [15:0] bbox_w_o,
  output logic [15:0] bbox_h_o,
  output logic [15:0] advance_o,
  output logic [15:0] count_value_o,
  output logic signed [15:0] point_x_o,
  output logic signed [15:0] point_y_o,
  output logic [2:0]  status_o,
  output logic        last_of_run_o
);

  push_t   push;
  result_t head;
  logic    full;
  logic    accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  vfcp_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (accept),
    .data_byte_i,
    .end_of_file_i,
    .push_o        (push)
  );

  vfcp_back u_back (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .full_o      (full),
    .out_valid_o,
    .out_stall_i,
    .head_o      (head)
  );

  assign kind_o        = head.kind;
  assign codepoint_o   = head.codepoint;
  assign bbox_x_o      = head.bbox_x;
  assign bbox_y_o      = head.bbox_y;
  assign bbox_w_o      = head.bbox_w;
  assign bbox_h_o      = head.bbox_h;
  assign advance_o     = head.advance;
  assign count_value_o = head.count_value;
  assign point_x_o     = head.point_x;
  assign point_y_o     = head.point_y;
  assign status_o      = head.status;
  assign last_of_run_o = head.last_of_run;

endmodule

### tb/vector_font_container_parser_test.sv
// Self-checking testbench for vector_font_container_parser: directed table, then random font files.
// Depends on vfcp_pkg and the parser RTL; expected records come from an in-bench file decoder.
`timescale 1ns / 1ps
module vector_font_container_parser_test;
  import vfcp_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldCycles    = 300;

  typedef struct {
    logic [7:0] data;
    logic       eof;
    logic       known;
    logic [2:0] code;
  } byte_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        end_of_file_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  kind_o;
  logic [15:0] codepoint_o;
  logic signed [15:0] bbox_x_o;
  logic signed [15:0] bbox_y_o;
  logic [15:0] bbox_w_o;
  logic [15:0] bbox_h_o;
  logic [15:0] advance_o;
  logic [15:0] count_value_o;
  logic signed [15:0] point_x_o;
  logic signed [15:0] point_y_o;
  logic [2:0]  status_o;
  logic        last_of_run_o;

  vector_font_container_parser u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .end_of_file_i,
    .out_valid_o, .out_stall_i, .kind_o, .codepoint_o, .bbox_x_o, .bbox_y_o,
    .bbox_w_o, .bbox_h_o, .advance_o, .count_value_o, .point_x_o, .point_y_o,
    .status_o, .last_of_run_o
  );

  // Decoder state.
  phase_e      dec_phase;
  logic [3:0]  dec_pos;
  logic [7:0]  dec_bytes [RecBytes];
  logic [15:0] dec_flags;
  logic [15:0] dec_glyphs_left;
  logic [15:0] dec_decl_contours;
  logic [15:0] dec_decl_points;
  logic [16:0] dec_claim_contours;
  logic [16:0] dec_claim_points;
  logic [15:0] dec_points_left;

  result_t   step_records [$];
  result_t   expected_records [$];
  byte_row_t file_stream [$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  idle_cycles = 0;
  bit  calm = 0;
  bit  hold_request = 0;
  bit  stimulus_done = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] rd8(input int unsigned i);
    return (i < dec_pos) ? {8'h00, dec_bytes[i]} : 16'h0000;
  endfunction

  function automatic logic [15:0] rd16(input int unsigned i);
    logic [15:0] hi;
    logic [15:0] lo;
    hi = rd8(i);
    lo = rd8(i + 1);
    return {hi[7:0], lo[7:0]};
  endfunction

  function automatic logic [15:0] sx8(input logic [15:0] b);
    return {{8{b[7]}}, b[7:0]};
  endfunction

  function automatic logic [16:0] add_sat(input logic [16:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[17] ? Sat17 : s[16:0];
  endfunction

  task automatic close_file(input logic [2:0] code);
    result_t r;
    r = '0;
    r.kind = KindStatus;
    r.status = code;
    step_records.push_back(r);
    dec_phase = PhDone;
  endtask

  task automatic restart_file();
    dec_phase = PhMarker;
    dec_pos = '0;
    dec_flags = '0;
    dec_glyphs_left = '0;
    dec_decl_contours = '0;
    dec_decl_points = '0;
    dec_claim_contours = '0;
    dec_claim_points = '0;
    dec_points_left = '0;
  endtask

  task automatic contours_done();
    if (dec_claim_points > {1'b0, dec_decl_points}) begin
      close_file(StBadHeader);
    end else begin
      dec_points_left = dec_claim_points[15:0];
      if (dec_points_left == 0) close_file(StOk);
      else dec_phase = PhPoint;
    end
  endtask

  task automatic glyphs_done();
    if (dec_claim_contours > {1'b0, dec_decl_contours}) close_file(StBadHeader);
    else if (dec_claim_contours == 0) contours_done();
    else dec_phase = PhContour;
  endtask

  task automatic header_record(input logic [15:0] units);
    result_t r;
    r = '0;
    r.kind = KindHeader;
    r.codepoint = dec_glyphs_left;
    r.bbox_w = dec_decl_contours;
    r.bbox_h = dec_decl_points;
    r.advance = dec_flags;
    r.count_value = units;
    step_records.push_back(r);
    if (dec_glyphs_left == 0) glyphs_done();
    else dec_phase = PhGlyph;
  endtask

  function automatic int unsigned record_len();
    logic wide;
    wide = (dec_flags & FlagWide) != 0;
    case (dec_phase)
      PhMarker:  return 4;
      PhHeader:  return 8;
      PhUnits:   return 2;
      PhGlyph:   return wide ? 13 : 8;
      PhContour: return (dec_flags & FlagLen16) ? 2 : 1;
      default:   return wide ? 4 : 2;
    endcase
  endfunction

  function automatic logic [2:0] truncation_code();
    logic [16:0] partial;
    case (dec_phase)
      PhMarker: return StBadMarker;
      PhHeader: return (rd16(0) & FlagsUnknown) != 0 ? StBadFlags : StTruncated;
      PhGlyph:
        return dec_claim_contours > {1'b0, dec_decl_contours} ? StBadHeader : StTruncated;
      PhContour: begin
        partial = ((dec_flags & FlagLen16) && dec_pos == 1) ? {1'b0, rd8(0) << 8} : '0;
        return add_sat(dec_claim_points, partial) > {1'b0, dec_decl_points} ?
               StBadHeader : StTruncated;
      end
      default: return StTruncated;
    endcase
  endfunction

  task automatic decode_record();
    result_t r;
    logic wide;
    logic [15:0] v;
    wide = (dec_flags & FlagWide) != 0;
    r = '0;
    case (dec_phase)
      PhMarker: begin
        if (dec_bytes[0] != Marker0 || dec_bytes[1] != Marker1 ||
            dec_bytes[2] != Marker2 || dec_bytes[3] != Marker3) close_file(StBadMarker);
        else dec_phase = PhHeader;
      end
      PhHeader: begin
        dec_flags = rd16(0);
        dec_glyphs_left = rd16(2);
        dec_decl_contours = rd16(4);
        dec_decl_points = rd16(6);
        if ((dec_flags & FlagsUnknown) != 0) close_file(StBadFlags);
        else if (dec_flags & FlagWide) dec_phase = PhUnits;
        else header_record(DefaultUnits);
      end
      PhUnits: begin
        v = rd16(0);
        if (v == 0) close_file(StBadHeader);
        else header_record(v);
      end
      PhGlyph: begin
        r.kind = KindGlyph;
        r.codepoint = rd16(0);
        if (wide) begin
          r.bbox_x = rd16(2);
          r.bbox_y = rd16(4);
          r.bbox_w = rd16(6);
          r.bbox_h = rd16(8);
          r.advance = rd16(10);
          v = rd8(12);
        end else begin
          r.bbox_x = sx8(rd8(2));
          r.bbox_y = sx8(rd8(3));
          r.bbox_w = rd8(4);
          r.bbox_h = rd8(5);
          r.advance = rd8(6);
          v = rd8(7);
        end
        r.count_value = v;
        step_records.push_back(r);
        dec_claim_contours = add_sat(dec_claim_contours, {1'b0, v});
        dec_glyphs_left = dec_glyphs_left - 1;
        if (dec_glyphs_left == 0) glyphs_done();
      end
      PhContour: begin
        v = (dec_flags & FlagLen16) ? rd16(0) : rd8(0);
        r.kind = KindContour;
        r.count_value = v;
        step_records.push_back(r);
        dec_claim_points = add_sat(dec_claim_points, {1'b0, v});
        dec_claim_contours = dec_claim_contours - 1;
        if (dec_claim_contours == 0) contours_done();
      end
      PhPoint: begin
        r.kind = KindPoint;
        if (wide) begin
          r.point_x = rd16(0);
          r.point_y = rd16(2);
        end else begin
          r.point_x = sx8(rd8(0));
          r.point_y = sx8(rd8(1));
        end
        step_records.push_back(r);
        dec_points_left = dec_points_left - 1;
        if (dec_points_left == 0) close_file(StOk);
      end
      default: ;
    endcase
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eof);
    result_t r;
    step_records.delete();
    if (eof) begin
      if (dec_phase != PhDone) close_file(truncation_code());
      restart_file();
    end else if (dec_phase != PhDone) begin
      if (dec_pos < RecBytes) dec_bytes[dec_pos] = b;
      dec_pos = dec_pos + 1;
      if (dec_pos >= record_len()) begin
        decode_record();
        dec_pos = '0;
      end
    end
    if (step_records.size() > 0) begin
      r = step_records[step_records.size() - 1];
      r.last_of_run = 1'b1;
      step_records[step_records.size() - 1] = r;
    end
    foreach (step_records[i]) expected_records.push_back(step_records[i]);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic eof);
    byte_row_t row;
    row.data = b;
    row.eof = eof;
    row.known = 1'b0;
    row.code = '0;
    file_stream.push_back(row);
  endtask

  task automatic add_word(input logic [15:0] w);
    add_byte(w[15:8], 1'b0);
    add_byte(w[7:0], 1'b0);
  endtask

  // Builds one random file: mostly well formed, with corrupted counts, truncation,
  // trailing bytes or plain noise now and then.
  task automatic build_random_file();
    logic [7:0]  body [$];
    logic [15:0] flags;
    logic [15:0] w;
    int unsigned n_glyphs, n_contours, n_points, c, len, cut, i, j;
    logic wide;
    if ($urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 1)) begin
        body.push_back(Marker0); body.push_back(Marker1);
        body.push_back(Marker2); body.push_back(Marker3);
      end
      repeat ($urandom_range(1, 16)) body.push_back(8'($urandom));
    end else begin
      flags = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 14) == 0) flags = 16'($urandom);
      wide = flags[1];
      body.push_back(Marker0); body.push_back(Marker1);
      body.push_back(Marker2); body.push_back(Marker3);
      if ($urandom_range(0, 19) == 0) body[$urandom_range(0, 3)] = 8'($urandom);
      n_glyphs = $urandom_range(0, 3);
      n_contours = 0;
      n_points = 0;
      body.push_back(flags[15:8]); body.push_back(flags[7:0]);
      body.push_back(8'h00); body.push_back(n_glyphs[7:0]);
      // Declared totals are patched once the glyph and contour sections are known.
      repeat (4) body.push_back(8'h00);
      if (wide) begin
        w = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
        body.push_back(w[15:8]); body.push_back(w[7:0]);
      end
      for (i = 0; i < n_glyphs; i++) begin
        c = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2);
        repeat (wide ? 12 : 7) body.push_back(8'($urandom));
        body.push_back(c[7:0]);
        n_contours += c;
      end
      for (i = 0; i < n_contours && i < 6; i++) begin
        if (flags[0]) begin
          len = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
          body.push_back(len[15:8]); body.push_back(len[7:0]);
        end else begin
          len = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
          body.push_back(len[7:0]);
        end
        n_points += len;
      end
      for (i = 0; i < n_points && i < 10; i++)
        for (j = 0; j < (wide ? 4 : 2); j++) body.push_back(8'($urandom));
      w = n_contours[15:0];
      if ($urandom_range(0, 5) == 0) w = 16'($urandom_range(0, n_contours + 1));
      body[8] = w[15:8]; body[9] = w[7:0];
      w = n_points[15:0];
      if ($urandom_range(0, 5) == 0) w = 16'($urandom_range(0, n_points + 1));
      body[10] = w[15:8]; body[11] = w[7:0];
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(0, body.size());
        while (body.size() > cut) void'(body.pop_back());
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
    end
    foreach (body[k]) add_byte(body[k], 1'b0);
    add_byte(8'($urandom), 1'b1);
  endtask

  task automatic load_directed_rows();
    // Known outcome for a row: {data, eof, known, status of the closing record}.
    byte_row_t rows [$] = '{
      '{8'hFF, 1'b1, 1'b1, StBadMarker},
      '{Marker0, 1'b0, 1'b0, StOk}, '{Marker1, 1'b0, 1'b0, StOk},
      '{Marker2, 1'b0, 1'b0, StOk}, '{8'h00, 1'b0, 1'b1, StBadMarker},
      '{8'hA5, 1'b0, 1'b0, StOk},   '{8'h00, 1'b1, 1'b0, StOk},
      '{Marker0, 1'b0, 1'b0, StOk}, '{Marker1, 1'b0, 1'b0, StOk},
      '{Marker2, 1'b0, 1'b0, StOk}, '{Marker3, 1'b0, 1'b0, StOk},
      '{8'hFF, 1'b0, 1'b0, StOk},   '{8'h00, 1'b1, 1'b1, StBadFlags},
      '{Marker0, 1'b0, 1'b0, StOk}, '{Marker1, 1'b0, 1'b0, StOk},
      '{Marker2, 1'b0, 1'b0, StOk}, '{Marker3, 1'b0, 1'b0, StOk},
      '{8'h00, 1'b0, 1'b0, StOk},   '{8'h00, 1'b0, 1'b0, StOk},
      '{8'h00, 1'b0, 1'b0, StOk},   '{8'h00, 1'b0, 1'b0, StOk},
      '{8'h00, 1'b0, 1'b0, StOk},   '{8'h00, 1'b0, 1'b0, StOk},
      '{8'h00, 1'b0, 1'b0, StOk},   '{8'h00, 1'b0, 1'b1, StOk},
      '{8'h00, 1'b1, 1'b0, StOk}
    };
    foreach (rows[i]) file_stream.push_back(rows[i]);
  endtask

  task automatic send_byte(input byte_row_t row);
    if (!calm && $urandom_range(0, 99) < 17) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= row.data;
    end_of_file_i <= row.eof;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(row.data, row.eof);
    if (row.known) begin
      if (step_records.size() == 0 || step_records[$].kind != KindStatus ||
          step_records[$].status != row.code) begin
        $display("%0t: directed row closing status expected %0d, decoder gives %0d",
                 $time, row.code, step_records.size() ? step_records[$].status : 3'd7);
        errors++;
      end
    end
    bytes_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    end_of_file_i = 1'b0;
    restart_file();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    load_directed_rows();
    while (file_stream.size() < 1026) build_random_file();
    while (file_stream.size() > 0) begin
      calm = bytes_sent >= 500 && bytes_sent < 700;
      send_byte(file_stream.pop_front());
    end
    in_valid_i <= 1'b0;
    stimulus_done = 1'b1;
  end

  initial begin
    wait (bytes_sent >= 300);
    hold_request = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_request = 1'b0;
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= hold_request || (!calm && $urandom_range(0, 99) < 17);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected record kind %0d status %0d", $time, kind_o, status_o);
        errors++;
      end else begin
        want = expected_records.pop_front();
        if (kind_o !== want.kind || codepoint_o !== want.codepoint ||
            bbox_x_o !== want.bbox_x || bbox_y_o !== want.bbox_y ||
            bbox_w_o !== want.bbox_w || bbox_h_o !== want.bbox_h ||
            advance_o !== want.advance || count_value_o !== want.count_value ||
            point_x_o !== want.point_x || point_y_o !== want.point_y ||
            status_o !== want.status || last_of_run_o !== want.last_of_run) begin
          $display("%0t: record mismatch expected kind %0d cp %h x %h y %h w %h h %h adv %h cnt %h px %h py %h st %0d last %b",
                   $time, want.kind, want.codepoint, want.bbox_x, want.bbox_y, want.bbox_w,
                   want.bbox_h, want.advance, want.count_value, want.point_x, want.point_y,
                   want.status, want.last_of_run);
          $display("%0t:                 actual   kind %0d cp %h x %h y %h w %h h %h adv %h cnt %h px %h py %h st %0d last %b",
                   $time, kind_o, codepoint_o, bbox_x_o, bbox_y_o, bbox_w_o, bbox_h_o,
                   advance_o, count_value_o, point_x_o, point_y_o, status_o, last_of_run_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (rst_ni);
    fork
      begin
        wait (stimulus_done && expected_records.size() == 0);
        repeat (20) @(posedge clk_i);
      end
      wait (idle_cycles >= WatchdogLimit);
    join_any
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired with %0d records outstanding", $time,
               expected_records.size());
      errors++;
    end else if (expected_records.size() != 0) begin
      $display("%0t: %0d records never arrived", $time, expected_records.size());
      errors++;
    end
    if (errors == 0) begin
      $display("vector_font_container_parser regression: pass");
    end else begin
      $display("vector_font_container_parser regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/vfcp_pkg.sv
rtl/core/vfcp_front.sv
rtl/core/vfcp_back.sv
rtl/core/vector_font_container_parser.sv
tb/vector_font_container_parser_test.sv
